/* rtl/core/pose_interpolator_lerp_nlerp_unit_defines.svh */
// Assertion macros shared by the pose interpolator RTL
`ifndef POSE_INTERPOLATOR_LERP_NLERP_UNIT_DEFINES_SVH
`define POSE_INTERPOLATOR_LERP_NLERP_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset
`define PSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be seen outside reset
`define PSI_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

/* rtl/core/psi_pkg.sv */
// Shared types and constants of the pose interpolator
`default_nettype none
package psi_pkg;

    // operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CLAMP     = 3'd1;
    localparam logic [2:0] ST_ZERO_INT  = 3'd2;
    localparam logic [2:0] ST_ZERO_NORM = 3'd3;
    localparam logic [2:0] ST_FEW       = 3'd4;

    localparam logic [15:0] Q_ONE = 16'd16384;

    localparam int JOBQ_DEPTH = 2;

    // shared divider limits
    localparam int DIV_QW  = 25;
    localparam int DIV_CW  = 5;
    localparam int DIV_RW  = 34;

    // query class decided by the front end
    typedef enum logic [2:0] {
        JOB_FEW  = 3'd0,
        JOB_ZERO = 3'd1,
        JOB_LO   = 3'd2,
        JOB_HI   = 3'd3,
        JOB_DIV  = 3'd4
    } job_code_t;

    // one query with its keyframe snapshot
    typedef struct packed {
        job_code_t         code;
        logic [31:0]       num;
        logic [31:0]       den;
        logic [2:0][31:0]  old_tr;
        logic [2:0][31:0]  new_tr;
        logic [3:0][15:0]  old_q;
        logic [3:0][15:0]  new_q;
    } job_t;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] steps;
        logic [31:0]       rem0;
        logic [31:0]       den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_QW-1:0] quot;
        logic [DIV_RW-2:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/psi_fifo.sv */
// Short job queue between front end and back end
`default_nettype none
module psi_fifo #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         wr_en,
    input  wire logic [W-1:0] wr_data,
    output logic              full,
    input  wire logic         rd_en,
    output logic [W-1:0]      rd_data,
    output logic              empty
);
    localparam int DEPTH = psi_pkg::JOBQ_DEPTH;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/psi_front.sv */
// Front end: keyframe store, query classification and time interval setup
`default_nettype none
module psi_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_operation,
    input  wire logic [31:0]         s_sample_time,
    input  wire logic signed [31:0]  s_in_tx,
    input  wire logic signed [31:0]  s_in_ty,
    input  wire logic signed [31:0]  s_in_tz,
    input  wire logic signed [15:0]  s_in_qx,
    input  wire logic signed [15:0]  s_in_qy,
    input  wire logic signed [15:0]  s_in_qz,
    input  wire logic signed [15:0]  s_in_qw,
    input  wire logic                jobq_full,
    output logic                     jobq_wr,
    output psi_pkg::job_t            jobq_data
);
    logic [31:0]      older_time_reg, newer_time_reg;
    logic [2:0][31:0] older_tr_reg, newer_tr_reg;
    logic [3:0][15:0] older_q_reg, newer_q_reg;
    logic [1:0]       held_reg;

    logic               xfer;
    logic signed [33:0] num_raw, den_raw, num_n, den_n;

    assign s_ready = !jobq_full;
    assign xfer    = s_valid && s_ready;
    assign jobq_wr = xfer && (s_operation == psi_pkg::OP_QUERY);

    // signed interval, flipped to a positive denominator
    always_comb begin
        num_raw = $signed({2'b00, s_sample_time}) - $signed({2'b00, older_time_reg});
        den_raw = $signed({2'b00, newer_time_reg}) - $signed({2'b00, older_time_reg});
        num_n   = den_raw[33] ? -num_raw : num_raw;
        den_n   = den_raw[33] ? -den_raw : den_raw;
    end

    // classify the query and snapshot the keyframes
    always_comb begin
        jobq_data.num    = num_n[31:0];
        jobq_data.den    = den_n[31:0];
        jobq_data.old_tr = older_tr_reg;
        jobq_data.new_tr = newer_tr_reg;
        jobq_data.old_q  = older_q_reg;
        jobq_data.new_q  = newer_q_reg;
        if (held_reg < 2'd2) begin
            jobq_data.code = psi_pkg::JOB_FEW;
        end else if (den_raw == '0) begin
            jobq_data.code = psi_pkg::JOB_ZERO;
        end else if (num_n[33]) begin
            jobq_data.code = psi_pkg::JOB_LO;
        end else if (num_n > den_n) begin
            jobq_data.code = psi_pkg::JOB_HI;
        end else begin
            jobq_data.code = psi_pkg::JOB_DIV;
        end
    end

    // keyframe shift on push
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_time_reg <= '0;
            newer_time_reg <= '0;
            older_tr_reg   <= '0;
            newer_tr_reg   <= '0;
            older_q_reg    <= '0;
            newer_q_reg    <= '0;
            held_reg       <= '0;
        end else if (xfer && (s_operation == psi_pkg::OP_PUSH)) begin
            older_time_reg <= newer_time_reg;
            newer_time_reg <= s_sample_time;
            older_tr_reg   <= newer_tr_reg;
            newer_tr_reg   <= {s_in_tz, s_in_ty, s_in_tx};
            older_q_reg    <= newer_q_reg;
            newer_q_reg    <= {s_in_qw, s_in_qz, s_in_qy, s_in_qx};
            if (held_reg < 2'd2) begin
                held_reg <= held_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/psi_div.sv */
// Shared restoring divider, one quotient bit per cycle
`default_nettype none
module psi_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire psi_pkg::div_req_t req,
    output psi_pkg::div_rsp_t      rsp
);
    logic                          busy_reg, done_reg;
    logic [psi_pkg::DIV_CW-1:0]    cnt_reg;
    logic [psi_pkg::DIV_RW-1:0]    rem_reg;
    logic [psi_pkg::DIV_QW-1:0]    quot_reg;
    logic [31:0]                   den_reg;

    logic                          ge;
    logic [psi_pkg::DIV_RW-1:0]    r1;

    // compare and subtract; the partial remainder stays below the divisor
    always_comb begin
        ge = (rem_reg >= {2'b00, den_reg});
        r1 = ge ? (rem_reg - {2'b00, den_reg}) : rem_reg;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg[psi_pkg::DIV_RW-1:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == psi_pkg::DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= {2'b00, req.rem0};
            den_reg  <= req.den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= {r1[psi_pkg::DIV_RW-2:0], 1'b0};
            quot_reg <= {quot_reg[psi_pkg::DIV_QW-2:0], ge};
        end
    end
endmodule
`default_nettype wire

/* rtl/core/psi_back.sv */
// Back end: fraction, lerp, quaternion normalization and result register
`default_nettype none
`include "pose_interpolator_lerp_nlerp_unit_defines.svh"
module psi_back #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                job_valid,
    input  wire psi_pkg::job_t       job_data,
    output logic                     job_pop,
    output psi_pkg::div_req_t        div_req,
    input  wire psi_pkg::div_rsp_t   div_rsp,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_out_tx,
    output logic signed [31:0]       m_out_ty,
    output logic signed [31:0]       m_out_tz,
    output logic signed [15:0]       m_out_qx,
    output logic signed [15:0]       m_out_qy,
    output logic signed [15:0]       m_out_qz,
    output logic signed [15:0]       m_out_qw,
    output logic [2:0]               m_status
);
    localparam int TW = FRACTION_BITS + 1;
    localparam int PW = 34 + TW + 1;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);
    localparam int SQ_STEPS = 17;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_TWAIT = 10'b00_0000_0010,
        S_DOT   = 10'b00_0000_0100,
        S_MUL   = 10'b00_0000_1000,
        S_ADD   = 10'b00_0001_0000,
        S_SQ    = 10'b00_0010_0000,
        S_SQRT  = 10'b00_0100_0000,
        S_QDIV  = 10'b00_1000_0000,
        S_QWAIT = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    state_t             state_reg;
    psi_pkg::job_t      job_reg;
    logic [TW-1:0]      t_reg;
    logic [2:0]         idx_reg;
    logic [4:0]         cnt_reg;
    logic signed [33:0] dot_reg;
    logic signed [PW-1:0] prod_reg;
    logic [31:0]        res_t_reg [3];
    logic signed [17:0] q_reg [4];
    logic [15:0]        oq_reg [4];
    logic [33:0]        sum_reg;
    logic [16:0]        root_reg;
    logic [18:0]        srem_reg;
    logic [2:0]         status_reg;
    logic               m_valid_reg;

    logic [1:0]         qi;
    logic               flip;
    logic signed [33:0] a_sel, b_sel, nq, diff, shifted, lerp_v;
    logic signed [TW:0] t_s;
    logic signed [PW-1:0] prod_rnd;
    logic signed [31:0] dot_p;
    logic signed [35:0] sq_p;
    logic [20:0]        rem2, trial;
    logic               sq_ge;
    logic signed [17:0] q_cur;
    logic [17:0]        qmag;
    logic [33:0]        rsum;
    logic               rinc;
    logic [15:0]        rq, rsat;
    logic               out_free;

    assign qi       = 2'(idx_reg - 3'd3);
    assign flip     = dot_reg[33] || (dot_reg == '0);
    assign t_s      = $signed({1'b0, t_reg});
    assign out_free = !m_valid_reg || m_ready;
    assign job_pop  = (state_reg == S_IDLE) && job_valid;

    // lerp operand select: translations first, then the quaternion
    always_comb begin
        if (idx_reg < 3'd3) begin
            a_sel = 34'($signed(job_reg.old_tr[idx_reg[1:0]]));
            nq    = 34'($signed(job_reg.new_tr[idx_reg[1:0]]));
            b_sel = nq;
        end else begin
            a_sel = 34'($signed(job_reg.old_q[qi]));
            nq    = 34'($signed(job_reg.new_q[qi]));
            b_sel = flip ? -nq : nq;
        end
        diff     = b_sel - a_sel;
        prod_rnd = prod_reg + HALF;
        shifted  = 34'(prod_rnd >>> FRACTION_BITS);
        lerp_v   = a_sel + shifted;
    end

    // dot product term, square term and one root digit
    always_comb begin
        dot_p = $signed(job_reg.old_q[idx_reg[1:0]]) * $signed(job_reg.new_q[idx_reg[1:0]]);
        sq_p  = q_reg[idx_reg[1:0]] * q_reg[idx_reg[1:0]];
        rem2  = {srem_reg, sum_reg[33:32]};
        trial = {2'b00, root_reg, 2'b01};
        sq_ge = (rem2 >= trial);
    end

    // component scaling with half-up rounding and saturation
    always_comb begin
        q_cur = q_reg[idx_reg[1:0]];
        qmag  = q_cur[17] ? 18'(-q_cur) : 18'(q_cur);
        rsum  = {1'b0, div_rsp.rem} + 34'(root_reg >> 1);
        rinc  = (rsum >= 34'(root_reg));
        rq    = 16'(div_rsp.quot[14:0]) + 16'(rinc);
        rsat  = (rq > psi_pkg::Q_ONE) ? psi_pkg::Q_ONE : rq;
    end

    // divider requests: fraction at job start, components later
    always_comb begin
        div_req = '0;
        if (job_pop && (job_data.code == psi_pkg::JOB_DIV)) begin
            div_req.start = 1'b1;
            div_req.steps = psi_pkg::DIV_CW'(TW);
            div_req.rem0  = job_data.num;
            div_req.den   = job_data.den;
        end else if (state_reg == S_QDIV) begin
            div_req.start = 1'b1;
            div_req.steps = psi_pkg::DIV_CW'(15);
            div_req.rem0  = 32'(qmag);
            div_req.den   = 32'(root_reg);
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        idx_reg <= '0;
                        case (job_data.code)
                            psi_pkg::JOB_FEW:  state_reg <= S_OUT;
                            psi_pkg::JOB_ZERO: state_reg <= S_OUT;
                            psi_pkg::JOB_DIV:  state_reg <= S_TWAIT;
                            default:           state_reg <= S_DOT;
                        endcase
                    end
                end
                S_TWAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= S_DOT;
                    end
                end
                S_DOT: begin
                    if (idx_reg == 3'd3) begin
                        idx_reg   <= '0;
                        state_reg <= S_MUL;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_MUL: state_reg <= S_ADD;
                S_ADD: begin
                    if (idx_reg == 3'd6) begin
                        idx_reg   <= '0;
                        state_reg <= S_SQ;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_SQ: begin
                    if (idx_reg == 3'd3) begin
                        idx_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SQRT: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(SQ_STEPS - 1)) begin
                        state_reg <= ({root_reg[15:0], sq_ge} == '0) ? S_OUT : S_QDIV;
                    end
                end
                S_QDIV: state_reg <= S_QWAIT;
                S_QWAIT: begin
                    if (div_rsp.done) begin
                        if (idx_reg == 3'd3) begin
                            state_reg <= S_OUT;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_QDIV;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                job_reg <= job_data;
                dot_reg <= '0;
                for (int i = 0; i < 3; i++) res_t_reg[i] <= '0;
                for (int i = 0; i < 4; i++) oq_reg[i] <= '0;
                case (job_data.code)
                    psi_pkg::JOB_FEW:  status_reg <= psi_pkg::ST_FEW;
                    psi_pkg::JOB_ZERO: status_reg <= psi_pkg::ST_ZERO_INT;
                    psi_pkg::JOB_LO: begin
                        status_reg <= psi_pkg::ST_CLAMP;
                        t_reg      <= '0;
                    end
                    psi_pkg::JOB_HI: begin
                        status_reg <= psi_pkg::ST_CLAMP;
                        t_reg      <= {1'b1, {FRACTION_BITS{1'b0}}};
                    end
                    default: status_reg <= psi_pkg::ST_OK;
                endcase
            end
            S_TWAIT: begin
                if (div_rsp.done) begin
                    t_reg <= div_rsp.quot[TW-1:0];
                end
            end
            S_DOT: dot_reg <= dot_reg + 34'(dot_p);
            S_MUL: prod_reg <= diff * t_s;
            S_ADD: begin
                if (idx_reg < 3'd3) begin
                    res_t_reg[idx_reg[1:0]] <= lerp_v[31:0];
                end else begin
                    q_reg[qi] <= lerp_v[17:0];
                end
                sum_reg <= '0;
            end
            S_SQ: begin
                sum_reg  <= sum_reg + sq_p[33:0];
                root_reg <= '0;
                srem_reg <= '0;
            end
            S_SQRT: begin
                srem_reg <= sq_ge ? 19'(rem2 - trial) : rem2[18:0];
                root_reg <= {root_reg[15:0], sq_ge};
                sum_reg  <= {sum_reg[31:0], 2'b00};
                if ((cnt_reg == 5'(SQ_STEPS - 1)) && ({root_reg[15:0], sq_ge} == '0)) begin
                    status_reg <= psi_pkg::ST_ZERO_NORM;
                end
            end
            S_QWAIT: begin
                if (div_rsp.done) begin
                    oq_reg[idx_reg[1:0]] <= q_cur[17] ? 16'(-rsat) : rsat;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_OUT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_OUT) && out_free) begin
            m_out_tx <= res_t_reg[0];
            m_out_ty <= res_t_reg[1];
            m_out_tz <= res_t_reg[2];
            m_out_qx <= oq_reg[0];
            m_out_qy <= oq_reg[1];
            m_out_qz <= oq_reg[2];
            m_out_qw <= oq_reg[3];
            m_status <= status_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `PSI_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
    `PSI_ASSERT(a_pop_nonempty, job_pop |-> job_valid, "job popped from empty queue")
    `PSI_ASSERT(a_done_expected, div_rsp.done |-> (state_reg == S_TWAIT || state_reg == S_QWAIT), "unexpected divider result")
    `PSI_NEVER(a_pop_busy, job_pop && div_rsp.busy, "new job while divider busy")
endmodule
`default_nettype wire

/* rtl/core/pose_interpolator_lerp_nlerp_unit.sv */
// Top level of the pose interpolator (keyframe lerp and quaternion nlerp)
//
//  Channel   Prefix  Handshake         Moves
//  input     s_      s_valid/s_ready   push keyframe or query time
//  result    m_      m_valid/m_ready   interpolated pose and status, one per query
//
// A push produces no result. A query holds the back end for one fraction
// division plus four component divisions of 15 steps on the shared divider,
// the 17-step square root and seven serial lerps on one multiplier. A clamped
// query skips the fraction division.
// Up to two queries wait in the job queue while the back end works; s_ready
// drops only when that queue is full. Reset is synchronous and clears the
// keyframes, the queue and the sequencer.
`default_nettype none
module pose_interpolator_lerp_nlerp_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_operation,
    input  wire logic [31:0]         s_sample_time,
    input  wire logic signed [31:0]  s_in_tx,
    input  wire logic signed [31:0]  s_in_ty,
    input  wire logic signed [31:0]  s_in_tz,
    input  wire logic signed [15:0]  s_in_qx,
    input  wire logic signed [15:0]  s_in_qy,
    input  wire logic signed [15:0]  s_in_qz,
    input  wire logic signed [15:0]  s_in_qw,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_out_tx,
    output logic signed [31:0]       m_out_ty,
    output logic signed [31:0]       m_out_tz,
    output logic signed [15:0]       m_out_qx,
    output logic signed [15:0]       m_out_qy,
    output logic signed [15:0]       m_out_qz,
    output logic signed [15:0]       m_out_qw,
    output logic [2:0]               m_status
);
    localparam int JW = $bits(psi_pkg::job_t);

    logic              jobq_full, jobq_wr, jobq_empty, job_pop;
    psi_pkg::job_t     jobq_wdata, jobq_rdata;
    logic [JW-1:0]     jobq_rbits;
    psi_pkg::div_req_t div_req;
    psi_pkg::div_rsp_t div_rsp;

    assign jobq_rdata = psi_pkg::job_t'(jobq_rbits);

    psi_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_sample_time (s_sample_time),
        .s_in_tx       (s_in_tx),
        .s_in_ty       (s_in_ty),
        .s_in_tz       (s_in_tz),
        .s_in_qx       (s_in_qx),
        .s_in_qy       (s_in_qy),
        .s_in_qz       (s_in_qz),
        .s_in_qw       (s_in_qw),
        .jobq_full     (jobq_full),
        .jobq_wr       (jobq_wr),
        .jobq_data     (jobq_wdata)
    );

    psi_fifo #(.W(JW)) u_jobq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (jobq_wr),
        .wr_data (JW'(jobq_wdata)),
        .full    (jobq_full),
        .rd_en   (job_pop),
        .rd_data (jobq_rbits),
        .empty   (jobq_empty)
    );

    psi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    psi_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (!jobq_empty),
        .job_data  (jobq_rdata),
        .job_pop   (job_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_tx  (m_out_tx),
        .m_out_ty  (m_out_ty),
        .m_out_tz  (m_out_tz),
        .m_out_qx  (m_out_qx),
        .m_out_qy  (m_out_qy),
        .m_out_qz  (m_out_qz),
        .m_out_qw  (m_out_qw),
        .m_status  (m_status)
    );
endmodule
`default_nettype wire
